// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the rasterizer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPL(name, cond, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

`endif

// ===== hdl/fcr_pkg.sv =====
// Shared types and constants of the filled circle rasterizer.
package fcr_pkg;

  // Screen bounds used for the off-screen reject test.
  localparam logic signed [13:0] SCREEN_WIDTH  = 14'sd800;
  localparam logic signed [13:0] SCREEN_HEIGHT = 14'sd480;

  // Decision variable constants.
  localparam logic signed [15:0] DEC_INIT = 16'sd3;
  localparam logic signed [15:0] INC_LOW  = 16'sd6;
  localparam logic signed [15:0] INC_HIGH = 16'sd10;

  // Item kinds carried on the input tuser.
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  // Index of the last dot in a step group.
  localparam logic [2:0] LAST_DOT = 3'd7;

  // Job queue between front and back.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  // One step group: centre, octant x, fill row and end-of-circle flag.
  typedef struct packed {
    logic signed [11:0] cx;
    logic signed [11:0] cy;
    logic        [10:0] x;
    logic        [10:0] r;
    logic               done;
  } fcr_job_t;

endpackage

// ===== hdl/filled_circle_rasterizer.sv =====
// A step goes through the job queue and the job register before its first dot is output.
// Output is one dot per cycle while m_tready holds; a step yields eight dots.
// Steps are paced by the single-dot output register of the emitter.
// Start items yield no dots; a four-deep job queue buffers steps.
// Reset (synchronous, active high) drops any circle, empties the queue and the output.
module filled_circle_rasterizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // center_x[11:0], center_y[23:12], radius[33:24], zero
  input  logic        s_tuser,  // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // pixel_x[12:0], pixel_y[25:13], zero
  output logic        m_tlast,  // last
  output logic        m_tuser   // circle_done
);
  import fcr_pkg::*;

  logic     q_full;
  logic     q_push;
  fcr_job_t q_in;
  logic     q_valid;
  logic     q_pop;
  fcr_job_t q_out;

  fcr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_in)
  );

  fcr_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .pop_job  (q_out)
  );

  fcr_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_job    (q_out),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== hdl/fcr_front.sv =====
// Front end: accepts start and step items, tracks the circle and queues step groups.
module fcr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [39:0]       s_tdata,  // center_x[11:0], center_y[23:12], radius[33:24], zero
  input  logic              s_tuser,  // mode
  input  logic              q_full,
  output logic              q_push,
  output fcr_pkg::fcr_job_t q_job
);
  import fcr_pkg::*;

  logic signed [11:0] centre_col;
  logic signed [11:0] centre_row;
  logic        [10:0] octant_x;
  logic signed [10:0] octant_y;
  logic        [10:0] fill_row;
  logic signed [15:0] decision;
  logic               active;

  logic               accept;
  logic signed [11:0] in_cx;
  logic signed [11:0] in_cy;
  logic        [9:0]  in_r;
  logic signed [13:0] cx_w;
  logic signed [13:0] cy_w;
  logic signed [13:0] r_w;
  logic               reject;
  logic               row_more;
  logic               dec_neg;
  logic signed [15:0] x16;
  logic signed [15:0] y16;
  logic signed [15:0] decision_next;
  logic signed [11:0] x_inc;
  logic signed [11:0] x_inc2;
  logic signed [11:0] y12;
  logic               done_next;

  // Unpack the input transfer.
  assign in_cx = s_tdata[11:0];
  assign in_cy = s_tdata[23:12];
  assign in_r  = s_tdata[33:24];

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  // Reject a circle lying wholly off screen.
  assign cx_w   = {{2{in_cx[11]}}, in_cx};
  assign cy_w   = {{2{in_cy[11]}}, in_cy};
  assign r_w    = {4'b0, in_r};
  assign reject = (cx_w + r_w < 14'sd0) || (cx_w - r_w >= SCREEN_WIDTH) ||
                  (cy_w + r_w < 14'sd0) || (cy_w - r_w >= SCREEN_HEIGHT);

  // Decide the next row, decision variable and end of circle.
  assign y12      = {octant_y[10], octant_y};
  assign row_more = $signed({1'b0, fill_row}) < y12;
  assign dec_neg  = decision < 16'sd0;
  assign x16      = {5'b0, octant_x};
  assign y16      = {{5{octant_y[10]}}, octant_y};
  assign x_inc    = $signed({1'b0, octant_x}) + 12'sd1;
  assign x_inc2   = $signed({1'b0, octant_x}) + 12'sd2;

  always_comb begin
    if (dec_neg) begin
      decision_next = decision + (x16 <<< 2) + INC_LOW;
      done_next     = x_inc > y12;
    end else begin
      decision_next = decision + ((x16 - y16) <<< 2) + INC_HIGH;
      done_next     = x_inc2 > y12;
    end
  end

  // Queue a group for every step while a circle runs.
  assign q_push   = accept && (s_tuser == MODE_STEP) && active;
  assign q_job.cx = centre_col;
  assign q_job.cy = centre_row;
  assign q_job.x  = octant_x;
  assign q_job.r  = fill_row;
  assign q_job.done = !row_more && done_next;

  // Hold and advance circle state.
  always_ff @(posedge clk) begin
    if (rst) begin
      centre_col <= '0;
      centre_row <= '0;
      octant_x   <= '0;
      octant_y   <= '0;
      fill_row   <= '0;
      decision   <= '0;
      active     <= 1'b0;
    end else if (accept) begin
      if (s_tuser == MODE_START) begin
        if (reject) begin
          active <= 1'b0;
        end else begin
          centre_col <= in_cx;
          centre_row <= in_cy;
          octant_x   <= '0;
          octant_y   <= $signed({1'b0, in_r});
          fill_row   <= '0;
          decision   <= DEC_INIT - $signed({5'b0, in_r, 1'b0});
          active     <= 1'b1;
        end
      end else if (active) begin
        if (row_more) begin
          fill_row <= fill_row + 11'd1;
        end else begin
          decision <= decision_next;
          if (!dec_neg) begin
            octant_y <= octant_y - 11'sd1;
          end
          octant_x <= x_inc[10:0];
          fill_row <= x_inc[10:0];
          if (done_next) begin
            active <= 1'b0;
          end
        end
      end
    end
  end

endmodule

// ===== hdl/fcr_fifo.sv =====
// Short job queue between the front end and the dot emitter.
module fcr_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  fcr_pkg::fcr_job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output fcr_pkg::fcr_job_t pop_job
);
  import fcr_pkg::*;

  fcr_job_t             mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wptr;
  logic [FIFO_AW-1:0]   rptr;
  logic [FIFO_AW:0]     count;

  assign full    = count == (FIFO_AW + 1)'(FIFO_DEPTH);
  assign valid   = count != '0;
  assign pop_job = mem[rptr];

  // Store pushed jobs.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_job;
    end
  end

  // Advance pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== hdl/fcr_emit.sv =====
// Back end: expands each queued group into eight mirrored dots, one per cycle while m_tready holds.
module fcr_emit (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  fcr_pkg::fcr_job_t q_job,
  output logic              q_pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata,  // pixel_x[12:0], pixel_y[25:13], zero
  output logic              m_tlast,  // last
  output logic              m_tuser   // circle_done
);
  import fcr_pkg::*;
  `include "assert_macros.svh"

  fcr_job_t           job;
  logic               busy;
  logic [2:0]         idx;
  logic               load;
  logic        [10:0] off_a;
  logic        [10:0] off_b;
  logic signed [12:0] px;
  logic signed [12:0] py;

  // Pick offsets: the upper four dots swap x and row.
  assign off_a = idx[2] ? job.r : job.x;
  assign off_b = idx[2] ? job.x : job.r;

  always_comb begin
    if (idx[0]) begin
      px = {job.cx[11], job.cx} - $signed({2'b0, off_a});
    end else begin
      px = {job.cx[11], job.cx} + $signed({2'b0, off_a});
    end
    if (idx[1]) begin
      py = {job.cy[11], job.cy} - $signed({2'b0, off_b});
    end else begin
      py = {job.cy[11], job.cy} + $signed({2'b0, off_b});
    end
  end

  // Take the next group when idle or as the current one finishes.
  assign load  = !m_tvalid || m_tready;
  assign q_pop = q_valid && (!busy || (load && idx == LAST_DOT));

  // Hold the output register and step through the dots.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= busy;
      end
      if (load && busy) begin
        m_tdata <= {6'b0, py, px};
        m_tlast <= idx == LAST_DOT;
        m_tuser <= (idx == LAST_DOT) && job.done;
        idx     <= idx + 3'd1;
      end
      if (q_pop) begin
        job  <= q_job;
        busy <= 1'b1;
      end else if (load && busy && idx == LAST_DOT) begin
        busy <= 1'b0;
      end
    end
  end

  `ASSERT_IMPL(a_done_on_last, m_tvalid && m_tuser, m_tlast, "circle end off a group end")
  `ASSERT_IMPL(a_idle_index, !busy, idx == 3'd0, "dot index moved while idle")
  `ASSERT_IMPL(a_pop_boundary, q_pop, !busy || idx == LAST_DOT, "group popped mid-group")

endmodule
